// ===== hw/rtl/imh_pkg.sv =====
package imh_pkg;

    localparam int unsigned IdW    = 8;
    localparam int unsigned NumIds = 256;
    localparam int unsigned PrioW  = 32;
    localparam int unsigned CntW   = 9;

    typedef enum logic [2:0] {
        ACT_INSERT   = 3'd0,
        ACT_EXTRACT  = 3'd1,
        ACT_DECREASE = 3'd2,
        ACT_INCREASE = 3'd3,
        ACT_QUERY    = 3'd4,
        ACT_PEEK     = 3'd5
    } t_action;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FULL    = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_PRESENT = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_DISPATCH,
        S_ROOT_RD,
        S_EXT_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_QUERY,
        S_DONE
    } t_state;

    // Write request to the heap slot memory.
    typedef struct packed {
        logic             en;
        logic [15:0]      addr;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } t_slot_wr;

    // Write request to the id tables.
    typedef struct packed {
        logic           en;
        logic [IdW-1:0] id;
        logic [15:0]    slot;
        logic           present;
        logic           slot_en;
    } t_id_wr;

    function automatic logic prio_lt(input logic [PrioW-1:0] a, input logic [PrioW-1:0] b);
        prio_lt = $signed(a) < $signed(b);
    endfunction

endpackage

// ===== hw/rtl/indexed_min_heap.sv =====
// Every word passes the look-up and dispatch states; an error or an unused action then goes
// straight to done, peek reads the root, query reads the entry's slot, and a sift walks the
// heap one level at a time, each level through a slot memory read state and then a compare-
// and-write state. The block works on one word at a time; the next is taken only once the
// result has left the output register.
// Reset (synchronous, active low) empties the heap and clears the presence bits.
module indexed_min_heap
    import imh_pkg::*;
#(
    parameter int unsigned CAPACITY = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_action,
    input  logic [7:0]              i_item_id,
    input  logic signed [31:0]      i_item_priority,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [7:0]              o_out_id,
    output logic signed [31:0]      o_out_priority,
    output logic                    o_found,
    output logic [8:0]              o_entry_count,
    output logic [2:0]              o_status
);

    localparam int unsigned SlotW = (CAPACITY > 256) ? $clog2(CAPACITY) : 8;
    localparam int unsigned CountW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;
    logic [2:0]        r_act;
    logic [IdW-1:0]    r_id;
    logic [PrioW-1:0]  r_prio;
    logic [CountW-1:0] r_count, n_count;
    logic [SlotW-1:0]  r_pos, n_pos;
    logic [IdW-1:0]    r_cur_id, n_cur_id;
    logic [PrioW-1:0]  r_cur_prio, n_cur_prio;
    logic              r_ovalid, n_ovalid;
    logic [7:0]        r_oid, n_oid;
    logic [31:0]       r_oprio, n_oprio;
    logic              r_ofound, n_ofound;
    logic [2:0]        r_ostatus, n_ostatus;

    logic [SlotW-1:0]  rd_a, rd_b;
    logic [IdW-1:0]    id_a, id_b;
    logic [PrioW-1:0]  prio_a, prio_b;
    logic              s_wr_en;
    logic [SlotW-1:0]  s_wr_addr;
    logic [IdW-1:0]    s_wr_id;
    logic [PrioW-1:0]  s_wr_prio;
    logic [SlotW-1:0]  id_slot;
    logic              id_pres;
    t_id_wr            id_wr;

    logic [SlotW:0]    c1, c2;
    logic              c1_ok, c2_ok, take_b;
    logic [SlotW-1:0]  up_par;

    imh_slot_mem #(.Capacity(CAPACITY), .SlotW(SlotW)) u_slot (
        .i_clk(i_clk), .i_rd_a(rd_a), .i_rd_b(rd_b),
        .o_id_a(id_a), .o_prio_a(prio_a), .o_id_b(id_b), .o_prio_b(prio_b),
        .i_wr_en(s_wr_en), .i_wr_addr(s_wr_addr), .i_wr_id(s_wr_id),
        .i_wr_prio(s_wr_prio)
    );

    imh_id_mem #(.SlotW(SlotW)) u_id (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rd_id(r_id),
        .o_slot(id_slot), .o_present(id_pres), .i_wr(id_wr)
    );

    // A new word waits until the previous result has been taken.
    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_out_id = r_oid;
    assign o_out_priority = r_oprio;
    assign o_found = r_ofound;
    assign o_entry_count = 9'(r_count);
    assign o_status = r_ostatus;

    assign c1 = {r_pos, 1'b1};
    assign c2 = {r_pos, 1'b0} + (SlotW+1)'(2);
    assign c1_ok = ({1'b0, c1} < (SlotW+2)'(r_count));
    assign c2_ok = ({1'b0, c2} < (SlotW+2)'(r_count));
    // Right child wins unless the left is strictly smaller.
    assign take_b = c2_ok && !prio_lt(prio_a, prio_b);
    assign up_par = (r_pos - SlotW'(1)) >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
        if (i_valid && !o_stall) begin
            r_act <= i_action;
            r_id <= i_item_id;
            r_prio <= i_item_priority;
        end
        r_pos <= n_pos;
        r_cur_id <= n_cur_id;
        r_cur_prio <= n_cur_prio;
        r_oid <= n_oid;
        r_oprio <= n_oprio;
        r_ofound <= n_ofound;
        r_ostatus <= n_ostatus;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_valid && !o_stall) n_state = S_LOOK;
            S_LOOK:     n_state = S_DISPATCH;
            S_DISPATCH: begin
                n_state = S_DONE;
                case (r_act)
                    ACT_INSERT: begin
                        if (!id_pres && r_count != CountW'(CAPACITY)) n_state = S_UP_RD;
                    end
                    ACT_EXTRACT, ACT_PEEK: begin
                        if (r_count != '0) n_state = S_ROOT_RD;
                    end
                    ACT_DECREASE: if (id_pres) n_state = S_UP_RD;
                    ACT_INCREASE: if (id_pres) n_state = S_DN_RD;
                    ACT_QUERY:    if (id_pres) n_state = S_QUERY;
                    default:      n_state = S_DONE;
                endcase
            end
            S_ROOT_RD:  n_state = (r_act == ACT_EXTRACT) ? S_EXT_LAST : S_DONE;
            S_EXT_LAST: n_state = (r_count == '0) ? S_DONE : S_DN_RD;
            S_UP_RD:    n_state = (r_pos == '0) ? S_DONE : S_UP_CMP;
            S_UP_CMP:   n_state = prio_lt(r_cur_prio, prio_a) ? S_UP_RD : S_DONE;
            S_DN_RD:    n_state = c1_ok ? S_DN_CMP : S_DONE;
            S_DN_CMP: begin
                if (take_b ? prio_lt(prio_b, r_cur_prio) : prio_lt(prio_a, r_cur_prio)) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QUERY:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control. The moving entry is kept in registers and written
    // to its final slot only once; displaced entries are written as it passes.
    always_comb begin
        n_count = r_count;
        n_pos = r_pos;
        n_cur_id = r_cur_id;
        n_cur_prio = r_cur_prio;
        n_ovalid = r_ovalid && i_stall;
        n_oid = r_oid;
        n_oprio = r_oprio;
        n_ofound = r_ofound;
        n_ostatus = r_ostatus;
        rd_a = up_par;
        rd_b = '0;
        s_wr_en = 1'b0;
        s_wr_addr = r_pos;
        s_wr_id = r_cur_id;
        s_wr_prio = r_cur_prio;
        id_wr = '0;
        case (r_state)
            S_LOOK: begin
                n_oid = '0;
                n_oprio = '0;
                n_ofound = 1'b0;
                n_ostatus = ST_OK;
            end
            S_DISPATCH: begin
                n_cur_id = r_id;
                n_cur_prio = r_prio;
                n_pos = id_slot;
                case (r_act)
                    ACT_INSERT: begin
                        if (id_pres) begin
                            n_ostatus = ST_PRESENT;
                        end else if (r_count == CountW'(CAPACITY)) begin
                            n_ostatus = ST_FULL;
                        end else begin
                            n_pos = SlotW'(r_count);
                            n_count = r_count + CountW'(1);
                            id_wr = '{en: 1'b1, id: r_id, slot: '0, present: 1'b1,
                                      slot_en: 1'b0};
                        end
                    end
                    ACT_EXTRACT, ACT_PEEK: begin
                        if (r_count == '0) n_ostatus = ST_EMPTY;
                    end
                    ACT_DECREASE, ACT_INCREASE: begin
                        if (!id_pres) n_ostatus = ST_ABSENT;
                    end
                    default: ;
                endcase
                rd_a = '0;
                rd_b = SlotW'(r_count - CountW'(1));
            end
            S_ROOT_RD: begin
                n_oid = id_a;
                n_oprio = prio_a;
                if (r_act == ACT_EXTRACT) begin
                    id_wr = '{en: 1'b1, id: id_a, slot: '0, present: 1'b0, slot_en: 1'b0};
                    n_count = r_count - CountW'(1);
                    n_cur_id = id_b;
                    n_cur_prio = prio_b;
                    n_pos = '0;
                end
            end
            S_EXT_LAST: begin
                if (r_count != '0) begin
                    rd_a = SlotW'(c1);
                    rd_b = SlotW'(c2);
                end
            end
            S_UP_RD: begin
                rd_a = up_par;
                if (r_pos == '0) begin
                    s_wr_en = 1'b1;
                    id_wr = '{en: 1'b1, id: r_cur_id, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                end
            end
            S_UP_CMP: begin
                s_wr_en = 1'b1;
                if (prio_lt(r_cur_prio, prio_a)) begin
                    s_wr_id = id_a;
                    s_wr_prio = prio_a;
                    id_wr = '{en: 1'b1, id: id_a, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                    n_pos = up_par;
                end else begin
                    id_wr = '{en: 1'b1, id: r_cur_id, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                end
            end
            S_DN_RD: begin
                rd_a = SlotW'(c1);
                rd_b = SlotW'(c2);
                if (!c1_ok) begin
                    s_wr_en = 1'b1;
                    id_wr = '{en: 1'b1, id: r_cur_id, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                end
            end
            S_DN_CMP: begin
                s_wr_en = 1'b1;
                rd_a = take_b ? SlotW'({SlotW'(c2), 1'b1}) : SlotW'({SlotW'(c1), 1'b1});
                rd_b = take_b ? SlotW'({SlotW'(c2), 1'b0} + (SlotW+1)'(2))
                              : SlotW'({SlotW'(c1), 1'b0} + (SlotW+1)'(2));
                if (take_b ? prio_lt(prio_b, r_cur_prio) : prio_lt(prio_a, r_cur_prio)) begin
                    s_wr_id = take_b ? id_b : id_a;
                    s_wr_prio = take_b ? prio_b : prio_a;
                    id_wr = '{en: 1'b1, id: s_wr_id, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                    n_pos = take_b ? SlotW'(c2) : SlotW'(c1);
                end else begin
                    id_wr = '{en: 1'b1, id: r_cur_id, slot: 16'(r_pos), present: 1'b1,
                              slot_en: 1'b1};
                end
            end
            S_QUERY: begin
                rd_a = r_pos;
            end
            S_DONE: begin
                n_ovalid = 1'b1;
                if (r_act == ACT_QUERY && id_pres) begin
                    n_ofound = 1'b1;
                    n_oid = r_id;
                    n_oprio = prio_a;
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(CAPACITY))
        else $error("entry count exceeds capacity");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid)
        else $error("finished word not presented");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("input taken while busy");
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> $stable(r_count))
        else $error("count moved while idle");
`endif

endmodule

// ===== hw/rtl/imh_slot_mem.sv =====
module imh_slot_mem
    import imh_pkg::*;
#(
    parameter int unsigned Capacity = 256,
    parameter int unsigned SlotW    = 8
) (
    input  logic                 i_clk,
    input  logic [SlotW-1:0]     i_rd_a,
    input  logic [SlotW-1:0]     i_rd_b,
    output logic [IdW-1:0]       o_id_a,
    output logic [PrioW-1:0]     o_prio_a,
    output logic [IdW-1:0]       o_id_b,
    output logic [PrioW-1:0]     o_prio_b,
    input  logic                 i_wr_en,
    input  logic [SlotW-1:0]     i_wr_addr,
    input  logic [IdW-1:0]       i_wr_id,
    input  logic [PrioW-1:0]     i_wr_prio
);

    logic [IdW+PrioW-1:0] r_mem [Capacity];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_id, i_wr_prio};
        end
        {o_id_a, o_prio_a} <= r_mem[i_rd_a];
        {o_id_b, o_prio_b} <= r_mem[i_rd_b];
    end

endmodule

// ===== hw/rtl/imh_id_mem.sv =====
module imh_id_mem
    import imh_pkg::*;
#(
    parameter int unsigned SlotW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [IdW-1:0]    i_rd_id,
    output logic [SlotW-1:0]  o_slot,
    output logic              o_present,
    input  t_id_wr            i_wr
);

    logic [SlotW-1:0] r_slot [NumIds];
    logic [NumIds-1:0] r_present;

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.slot_en) begin
            r_slot[i_wr.id] <= i_wr.slot[SlotW-1:0];
        end
        o_slot <= r_slot[i_rd_id];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            o_present <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_present[i_wr.id] <= i_wr.present;
            end
            o_present <= r_present[i_rd_id];
        end
    end

endmodule
